/* sv/hdwc_pkg.sv */
package hdwc_pkg;

    // Window geometry
    localparam int WINDOW_LEN = 6;
    localparam int NUM_PAIRS  = 10;
    localparam int NUM_CRIT   = 6;
    localparam int SLOT_BITS  = 3;
    localparam int CRIT_BITS  = 3;
    localparam int FILL_BITS  = 3;

    // Coordinate and distance widths
    localparam int COORD_BITS  = 20;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int MAG_BITS    = COORD_BITS;
    localparam int SQ_BITS     = 2 * MAG_BITS;
    localparam int D2_BITS     = SQ_BITS + 2;
    localparam int SCALED_BITS = D2_BITS + 7;

    // Tolerance register and bound widths
    localparam int TOL_BITS    = 10;
    localparam int SD_BITS     = 7;
    localparam int BASE_BITS   = 17;
    localparam int SPREAD_BITS = SD_BITS + TOL_BITS;
    localparam int BOUND_BITS  = 18;
    localparam int BOUND2_BITS = 2 * BOUND_BITS;

    localparam logic [TOL_BITS-1:0] TOL_RESET = 10'd196;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_BITS-1:0]  t_diff;
    typedef logic [MAG_BITS-1:0]          t_mag;
    typedef logic [SQ_BITS-1:0]           t_sq;
    typedef logic [D2_BITS-1:0]           t_d2;
    typedef logic [SCALED_BITS-1:0]       t_scaled;
    typedef logic [BOUND_BITS-1:0]        t_bound;
    typedef logic [BOUND2_BITS-1:0]       t_bound2;
    typedef logic [SLOT_BITS-1:0]         t_slot;
    typedef logic [CRIT_BITS-1:0]         t_crit;
    typedef logic [FILL_BITS-1:0]         t_fill;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_point;

    // Squared distance bounds per criterion, derived from the tolerance
    typedef struct packed {
        logic [NUM_CRIT-1:0]    lo_neg;
        t_bound2 [NUM_CRIT-1:0] hi_sq;
        t_bound2 [NUM_CRIT-1:0] lo_sq;
    } t_bounds;

    // Window test outcome for one residue
    typedef struct packed {
        logic pass;
        logic last;
    } t_token;

    // Criteria: terminal/core spacing 2, terminal/core spacing 3, spacing 4, 5
    // Mean distances in units of 1e-4 A, deviations in hundredths of an angstrom
    localparam logic [BASE_BITS-1:0] CRIT_BASE [NUM_CRIT] =
        '{17'd55400, 17'd54900, 17'd53600, 17'd53000, 17'd63300, 17'd87200};
    localparam logic [SD_BITS-1:0] CRIT_SD [NUM_CRIT] =
        '{7'd25, 7'd20, 7'd39, 7'd64, 7'd71, 7'd63};

    // Pair list: spacing 2 (starts 0..3), 3 (0..2), 4 (0..1), 5 (0)
    localparam t_slot PAIR_A [NUM_PAIRS] =
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd1, 3'd2, 3'd0, 3'd1, 3'd0};
    localparam t_slot PAIR_B [NUM_PAIRS] =
        '{3'd2, 3'd3, 3'd4, 3'd5, 3'd3, 3'd4, 3'd5, 3'd4, 3'd5, 3'd5};
    localparam t_crit PAIR_CRIT [NUM_PAIRS] =
        '{3'd0, 3'd1, 3'd1, 3'd0, 3'd2, 3'd3, 3'd2, 3'd4, 3'd4, 3'd5};

endpackage

/* sv/hdwc_item_if.sv */
interface hdwc_item_if;
    logic                   valid;
    logic                   ready;
    hdwc_pkg::t_coord       pos_x;
    hdwc_pkg::t_coord       pos_y;
    hdwc_pkg::t_coord       pos_z;
    logic                   chain_end;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output chain_end, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input chain_end, output ready);
endinterface

/* sv/hdwc_label_if.sv */
interface hdwc_label_if;
    logic valid;
    logic ready;
    logic is_helix;
    logic final_label;

    modport source (output valid, output is_helix, output final_label, input ready);
    modport sink   (input valid, input is_helix, input final_label, output ready);
endinterface

/* sv/hdwc_cfg_if.sv */
interface hdwc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [hdwc_pkg::TOL_BITS-1:0]   tolerance_factor;

    modport source (output valid, output tolerance_factor, input ready);
    modport sink   (input valid, input tolerance_factor, output ready);
endinterface

/* sv/hdwc_bounds.sv */
module hdwc_bounds (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hdwc_cfg_if.sink          i_cfg,
    output hdwc_pkg::t_bounds o_bounds
);

    logic [hdwc_pkg::TOL_BITS-1:0]    r_tol;
    logic [hdwc_pkg::SPREAD_BITS-1:0] r_spread [hdwc_pkg::NUM_CRIT];
    hdwc_pkg::t_bounds                r_bounds;

    // Tolerance register, always writable
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= hdwc_pkg::TOL_RESET;
        end else if (i_cfg.valid) begin
            r_tol <= i_cfg.tolerance_factor;
        end
    end

    // Per criterion: spread = sd * tol, then squared upper and lower bounds
    for (genvar c = 0; c < hdwc_pkg::NUM_CRIT; c++) begin : g_crit
        logic [hdwc_pkg::BASE_BITS-1:0] base;
        hdwc_pkg::t_bound               hi;
        hdwc_pkg::t_bound               lo_mag;
        logic                           lo_neg;

        assign base   = hdwc_pkg::CRIT_BASE[c];
        assign hi     = hdwc_pkg::BOUND_BITS'(base) + hdwc_pkg::BOUND_BITS'(r_spread[c]);
        assign lo_neg = r_spread[c] > base;
        assign lo_mag = hdwc_pkg::BOUND_BITS'(base - r_spread[c]);

        always_ff @(posedge i_clk) begin
            r_spread[c] <= hdwc_pkg::SPREAD_BITS'(hdwc_pkg::CRIT_SD[c])
                         * hdwc_pkg::SPREAD_BITS'(r_tol);
            r_bounds.hi_sq[c]  <= hdwc_pkg::t_bound2'(hi) * hdwc_pkg::t_bound2'(hi);
            r_bounds.lo_sq[c]  <= hdwc_pkg::t_bound2'(lo_mag) * hdwc_pkg::t_bound2'(lo_mag);
            r_bounds.lo_neg[c] <= lo_neg;
        end
    end

    assign o_bounds = r_bounds;

endmodule

/* sv/hdwc_window_test.sv */
module hdwc_window_test (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hdwc_item_if.sink         i_item,
    input  hdwc_pkg::t_bounds i_bounds,
    output logic              o_tok_valid,
    output hdwc_pkg::t_token  o_tok,
    input  logic              i_tok_ready
);

    localparam int NP = hdwc_pkg::NUM_PAIRS;

    // Stage 1: window shift register
    hdwc_pkg::t_point r_win [hdwc_pkg::WINDOW_LEN];
    logic             r_v1, r_last1;
    // Stage 2: per-axis squares
    hdwc_pkg::t_sq    r_sq [NP][3];
    logic             r_v2, r_last2;
    // Stage 3: squared distances
    hdwc_pkg::t_d2    r_d2 [NP];
    logic             r_v3, r_last3;
    // Stage 4: window verdict
    logic             r_v4;
    hdwc_pkg::t_token r_tok4;

    logic             rdy2, rdy3, rdy4, accept;
    logic [NP-1:0]    pair_ok;
    hdwc_pkg::t_point new_pt;

    function automatic hdwc_pkg::t_mag abs_diff(hdwc_pkg::t_coord a, hdwc_pkg::t_coord b);
        hdwc_pkg::t_diff d;
        d = hdwc_pkg::t_diff'(b) - hdwc_pkg::t_diff'(a);
        return d[hdwc_pkg::DIFF_BITS-1] ? hdwc_pkg::MAG_BITS'(-d) : hdwc_pkg::MAG_BITS'(d);
    endfunction

    // Stage advance: a stage moves when the next one is empty or moving
    assign rdy4         = !r_v4 || i_tok_ready;
    assign rdy3         = !r_v3 || rdy4;
    assign rdy2         = !r_v2 || rdy3;
    assign i_item.ready = !r_v1 || rdy2;
    assign accept       = i_item.valid && i_item.ready;

    assign new_pt = '{x: i_item.pos_x, y: i_item.pos_y, z: i_item.pos_z};

    // Window: newest residue enters at the top slot
    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < hdwc_pkg::WINDOW_LEN - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[hdwc_pkg::WINDOW_LEN-1] <= new_pt;
            r_last1 <= i_item.chain_end;
        end
    end

    // Per pair: squares, sum, scaled compare against the bounds
    for (genvar p = 0; p < NP; p++) begin : g_pair
        localparam int A = hdwc_pkg::PAIR_A[p];
        localparam int B = hdwc_pkg::PAIR_B[p];
        localparam int C = hdwc_pkg::PAIR_CRIT[p];
        hdwc_pkg::t_mag    mx, my, mz;
        hdwc_pkg::t_scaled scaled;

        assign mx = abs_diff(r_win[A].x, r_win[B].x);
        assign my = abs_diff(r_win[A].y, r_win[B].y);
        assign mz = abs_diff(r_win[A].z, r_win[B].z);

        // d2 * 100 as shifts and adds
        assign scaled = (hdwc_pkg::SCALED_BITS'(r_d2[p]) << 6)
                      + (hdwc_pkg::SCALED_BITS'(r_d2[p]) << 5)
                      + (hdwc_pkg::SCALED_BITS'(r_d2[p]) << 2);

        assign pair_ok[p] = (scaled < hdwc_pkg::SCALED_BITS'(i_bounds.hi_sq[C]))
                         && (i_bounds.lo_neg[C]
                             || (scaled > hdwc_pkg::SCALED_BITS'(i_bounds.lo_sq[C])));

        always_ff @(posedge i_clk) begin
            if (rdy2) begin
                r_sq[p][0] <= hdwc_pkg::t_sq'(mx) * hdwc_pkg::t_sq'(mx);
                r_sq[p][1] <= hdwc_pkg::t_sq'(my) * hdwc_pkg::t_sq'(my);
                r_sq[p][2] <= hdwc_pkg::t_sq'(mz) * hdwc_pkg::t_sq'(mz);
            end
            if (rdy3) begin
                r_d2[p] <= hdwc_pkg::D2_BITS'(r_sq[p][0]) + hdwc_pkg::D2_BITS'(r_sq[p][1])
                         + hdwc_pkg::D2_BITS'(r_sq[p][2]);
            end
        end
    end

    // Control and end-of-chain flags through the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (i_item.ready) begin
                r_v1 <= i_item.valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_last2 <= r_last1;
        end
        if (rdy3) begin
            r_last3 <= r_last2;
        end
        if (rdy4) begin
            r_tok4.pass <= &pair_ok;
            r_tok4.last <= r_last3;
        end
    end

    assign o_tok_valid = r_v4;
    assign o_tok       = r_tok4;

    // Checks
    a_tok_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && !i_tok_ready |=> r_v4 && $stable(r_tok4))
        else $error("window verdict changed while stalled");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_v1)
        else $error("accepted residue did not enter the window stage");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !rdy3 |=> r_v2 && $stable(r_last2))
        else $error("squares stage overwritten while stalled");

endmodule

/* sv/hdwc_label_emit.sv */
module hdwc_label_emit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_tok_valid,
    input  hdwc_pkg::t_token i_tok,
    output logic             o_tok_ready,
    hdwc_label_if.source     o_label
);

    localparam int W = hdwc_pkg::WINDOW_LEN;

    logic [W-1:0]        r_marks;
    hdwc_pkg::t_fill     r_mfill;
    logic [W-1:0]        r_blab;
    hdwc_pkg::t_fill     r_bcnt;
    logic                r_bfinal;
    logic                r_ov, r_ohelix, r_ofinal;

    logic                out_free, take, tok_go, full_before, full_new;
    logic [W-1:0]        n_marks_upd;
    hdwc_pkg::t_fill     n_fill_upd;

    assign out_free    = !r_ov || o_label.ready;
    assign take        = (r_bcnt == '0) || ((r_bcnt == hdwc_pkg::FILL_BITS'(1)) && out_free);
    assign tok_go      = i_tok_valid && take;
    assign o_tok_ready = take;

    // Pending marks follow the window: shift when full, else fill the next slot
    assign full_before = r_mfill == hdwc_pkg::FILL_BITS'(W);

    always_comb begin
        if (full_before) begin
            n_marks_upd = {1'b0, r_marks[W-1:1]};
            n_fill_upd  = r_mfill;
        end else begin
            n_marks_upd = r_marks & ~(W'(1) << r_mfill);
            n_fill_upd  = r_mfill + hdwc_pkg::FILL_BITS'(1);
        end
        full_new = n_fill_upd == hdwc_pkg::FILL_BITS'(W);
        if (full_new && i_tok.pass) begin
            n_marks_upd = '1;
        end
    end

    // Mark state and label burst
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marks <= '0;
            r_mfill <= '0;
            r_bcnt  <= '0;
        end else if (tok_go) begin
            if (i_tok.last) begin
                r_marks <= '0;
                r_mfill <= '0;
                r_bcnt  <= n_fill_upd;
            end else begin
                r_marks <= n_marks_upd;
                r_mfill <= n_fill_upd;
                r_bcnt  <= full_new ? hdwc_pkg::FILL_BITS'(1) : '0;
            end
        end else if ((r_bcnt != '0) && out_free) begin
            r_bcnt <= r_bcnt - hdwc_pkg::FILL_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (tok_go) begin
            r_blab   <= i_tok.last ? n_marks_upd : {{(W-1){1'b0}}, n_marks_upd[0]};
            r_bfinal <= i_tok.last;
        end else if ((r_bcnt != '0) && out_free) begin
            r_blab <= r_blab >> 1;
        end
    end

    // Output register, one label per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_free) begin
            r_ov <= r_bcnt != '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_ohelix <= r_blab[0];
            r_ofinal <= r_bfinal && (r_bcnt == hdwc_pkg::FILL_BITS'(1));
        end
    end

    assign o_label.valid       = r_ov;
    assign o_label.is_helix    = r_ohelix;
    assign o_label.final_label = r_ofinal;

    // Checks
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mfill <= hdwc_pkg::FILL_BITS'(W))
        else $error("mark fill count out of range");

    a_burst_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bcnt <= hdwc_pkg::FILL_BITS'(W))
        else $error("label burst count out of range");

    a_burst_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bcnt != '0) && out_free |=> r_ov)
        else $error("pending label not moved to output");

    a_chain_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok_go && i_tok.last |=> (r_mfill == '0) && (r_marks == '0))
        else $error("marks not cleared at chain end");

endmodule

/* sv/helix_distance_window_classifier_core.sv */
// Stages: window, squares, distances, verdict; then the burst buffer and the output register.
// Throughput: one residue per cycle unless stalled; each full-window residue gives one label.
// A chain end emits all n pending labels one per cycle unless stalled; input waits for the burst.
// The output holds one label and a burst buffer, so input keeps flowing while a label waits.
// Reset (synchronous, active low) empties the window, marks and pipeline; tolerance returns to 196.
module helix_distance_window_classifier_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hdwc_item_if.sink    i_item,
    hdwc_cfg_if.sink     i_cfg,
    hdwc_label_if.source o_label
);

    hdwc_pkg::t_bounds bounds;
    hdwc_pkg::t_token  tok;
    logic              tok_valid;
    logic              tok_ready;

    // Tolerance register and squared bounds
    hdwc_bounds u_bounds (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .o_bounds (bounds)
    );

    // Window and pair distance test
    hdwc_window_test u_test (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_bounds    (bounds),
        .o_tok_valid (tok_valid),
        .o_tok       (tok),
        .i_tok_ready (tok_ready)
    );

    // Helix marks and label output
    hdwc_label_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (tok_valid),
        .i_tok       (tok),
        .o_tok_ready (tok_ready),
        .o_label     (o_label)
    );

endmodule

/* verif/hdwc_label_checker.sv */
module hdwc_label_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hdwc_item_if         i_item,
    hdwc_cfg_if          i_cfg,
    hdwc_label_if        i_label,
    output int           o_fail_count,
    output int           o_outstanding,
    output int           o_label_count,
    output int           o_helix_count
);

    typedef struct packed {
        logic is_helix;
        logic final_label;
    } t_residue_label;

    // Mirrored block state
    longint         win_x [hdwc_pkg::WINDOW_LEN];
    longint         win_y [hdwc_pkg::WINDOW_LEN];
    longint         win_z [hdwc_pkg::WINDOW_LEN];
    bit             helix_mark [hdwc_pkg::WINDOW_LEN];
    int             filled;
    longint         tol_setting;
    t_residue_label residue_labels [$];
    int             fails;

    function automatic void clear_window();
        int i;
        for (i = 0; i < hdwc_pkg::WINDOW_LEN; i++) begin
            win_x[i] = 0;
            win_y[i] = 0;
            win_z[i] = 0;
            helix_mark[i] = 1'b0;
        end
        filled = 0;
    endfunction

    // All ten pairs of spacing 2..5 must sit strictly inside their bounds
    function automatic bit window_is_helix(input longint tol);
        int     jump;
        int     start;
        int     b;
        bit     at_end;
        longint mean;
        longint sd;
        longint hi;
        longint lo;
        longint dx;
        longint dy;
        longint dz;
        longint d2;
        longint scaled;
        for (jump = 2; jump < hdwc_pkg::WINDOW_LEN; jump++) begin
            for (start = 0; start + jump < hdwc_pkg::WINDOW_LEN; start++) begin
                b = start + jump;
                at_end = (start == 0) || (b == hdwc_pkg::WINDOW_LEN - 1);
                case (jump)
                    2: begin
                        mean = at_end ? 554 : 549;
                        sd   = at_end ? 25 : 20;
                    end
                    3: begin
                        mean = at_end ? 536 : 530;
                        sd   = at_end ? 39 : 64;
                    end
                    4: begin
                        mean = 633;
                        sd   = 71;
                    end
                    default: begin
                        mean = 872;
                        sd   = 63;
                    end
                endcase
                hi = mean * 100 + sd * tol;
                lo = mean * 100 - sd * tol;
                dx = win_x[b] - win_x[start];
                dy = win_y[b] - win_y[start];
                dz = win_z[b] - win_z[start];
                d2 = dx * dx + dy * dy + dz * dz;
                scaled = d2 * 100;
                if (!(scaled < hi * hi))
                    return 1'b0;
                if (lo == 0) begin
                    if (d2 == 0)
                        return 1'b0;
                end else if (lo > 0) begin
                    if (!(scaled > lo * lo))
                        return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    // Shift in one residue, test the window and queue the labels it releases
    function automatic void classify_residue(input longint px, input longint py,
                                             input longint pz, input bit last);
        int             slot;
        int             i;
        t_residue_label lbl;
        if (filled >= hdwc_pkg::WINDOW_LEN) begin
            for (i = 0; i < hdwc_pkg::WINDOW_LEN - 1; i++) begin
                win_x[i] = win_x[i+1];
                win_y[i] = win_y[i+1];
                win_z[i] = win_z[i+1];
                helix_mark[i] = helix_mark[i+1];
            end
            slot = hdwc_pkg::WINDOW_LEN - 1;
        end else begin
            slot = filled;
            filled++;
        end
        win_x[slot] = px;
        win_y[slot] = py;
        win_z[slot] = pz;
        helix_mark[slot] = 1'b0;

        if (filled >= hdwc_pkg::WINDOW_LEN && window_is_helix(tol_setting)) begin
            for (i = 0; i < hdwc_pkg::WINDOW_LEN; i++)
                helix_mark[i] = 1'b1;
        end

        if (last) begin
            // chain end flushes every pending label, oldest first
            for (i = 0; i < filled; i++) begin
                lbl.is_helix    = helix_mark[i];
                lbl.final_label = (i + 1 == filled);
                residue_labels = {residue_labels, lbl};
            end
            clear_window();
        end else if (filled >= hdwc_pkg::WINDOW_LEN) begin
            lbl.is_helix    = helix_mark[0];
            lbl.final_label = 1'b0;
            residue_labels = {residue_labels, lbl};
        end
    endfunction

    // Watch all three channels at each edge
    always @(posedge i_clk) begin
        t_residue_label want;
        if (!i_rst_n) begin
            clear_window();
            tol_setting = hdwc_pkg::TOL_RESET;
            residue_labels.delete();
            fails = 0;
            o_label_count <= 0;
            o_helix_count <= 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready)
                tol_setting = i_cfg.tolerance_factor;

            if (i_item.valid && i_item.ready)
                classify_residue(longint'(i_item.pos_x), longint'(i_item.pos_y),
                                 longint'(i_item.pos_z), i_item.chain_end);

            if (i_label.valid && i_label.ready) begin
                o_label_count <= o_label_count + 1;
                if (i_label.is_helix)
                    o_helix_count <= o_helix_count + 1;
                if (residue_labels.size() == 0) begin
                    if (fails < 10)
                        $display("label transaction %0d with no residue label pending",
                                 o_label_count);
                    fails++;
                end else begin
                    want = residue_labels.pop_front();
                    if (want.is_helix !== i_label.is_helix ||
                        want.final_label !== i_label.final_label) begin
                        if (fails < 10)
                            $display({"label transaction %0d mismatch: expected ",
                                      "is_helix=%0b final_label=%0b, got ",
                                      "is_helix=%0b final_label=%0b"},
                                     o_label_count, want.is_helix, want.final_label,
                                     i_label.is_helix, i_label.final_label);
                        fails++;
                    end
                end
            end
        end
        o_fail_count  <= fails;
        o_outstanding <= residue_labels.size();
    end

endmodule

/* verif/helix_distance_window_classifier_core_tb.sv */
module helix_distance_window_classifier_core_tb;

    logic i_clk;
    logic i_rst_n;

    hdwc_item_if  item_ch ();
    hdwc_cfg_if   cfg_ch ();
    hdwc_label_if label_ch ();

    int fail_count;
    int outstanding;
    int labels_seen;
    int helix_seen;
    int residues_sent;
    int chains_closed;
    int send_idle_pct;
    int recv_idle_pct;

    helix_distance_window_classifier_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .i_cfg   (cfg_ch),
        .o_label (label_ch)
    );

    hdwc_label_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (item_ch),
        .i_cfg         (cfg_ch),
        .i_label       (label_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_label_count (labels_seen),
        .o_helix_count (helix_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the label stream hangs
    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Label receiver stalls at random
    initial begin
        label_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            label_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // One residue transaction, with optional idle cycles ahead of it
    task automatic send_residue(input longint x, input longint y, input longint z,
                                input bit last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.pos_x     <= hdwc_pkg::t_coord'(x);
        item_ch.pos_y     <= hdwc_pkg::t_coord'(y);
        item_ch.pos_z     <= hdwc_pkg::t_coord'(z);
        item_ch.chain_end <= last;
        @(posedge i_clk);
        while (!item_ch.ready)
            @(posedge i_clk);
        residues_sent++;
        if (last)
            chains_closed++;
    endtask

    task automatic send_noise(input bit last);
        send_residue(int'($urandom()), int'($urandom()), int'($urandom()), last);
    endtask

    function automatic int jitter_of(input int amp);
        if (amp == 0)
            return 0;
        return int'($urandom_range(0, 2 * amp)) - amp;
    endfunction

    // Ideal alpha helix: 2.3 A radius, 1.5 A rise, 100 degrees per residue
    task automatic send_helix_chain(input int n, input int amp, input bit close_chain,
                                    input int outlier);
        longint bx;
        longint by;
        longint bz;
        longint px;
        longint py;
        longint pz;
        int     rise;
        int     k;
        real    ang;
        bx = int'($urandom_range(0, 800000)) - 400000;
        by = int'($urandom_range(0, 800000)) - 400000;
        bz = int'($urandom_range(0, 600000)) - 300000;
        rise = $urandom_range(0, 1) ? 1500 : -1500;
        for (k = 0; k < n; k++) begin
            ang = k * 1.7453292519943295;
            px = bx + $rtoi(2300.0 * $cos(ang)) + jitter_of(amp);
            py = by + $rtoi(2300.0 * $sin(ang)) + jitter_of(amp);
            pz = bz + k * rise + jitter_of(amp);
            if (k == outlier)
                px = int'($urandom_range(0, 1000000)) - 500000;
            send_residue(px, py, pz, close_chain && (k == n - 1));
        end
    endtask

    // Hold input idle until every predicted label has been taken
    task automatic wait_for_labels();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_tolerance(input logic [hdwc_pkg::TOL_BITS-1:0] value);
        cfg_ch.valid            <= 1'b1;
        cfg_ch.tolerance_factor <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [hdwc_pkg::TOL_BITS-1:0] tolerance_for_phase(input int phase);
        case (phase)
            0:       return 10'd0;
            1:       return 10'd1023;
            2:       return 10'd1000;
            3:       return hdwc_pkg::TOL_RESET;
            4:       return 10'(300);
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    initial begin
        int phase;
        int phase_start;
        int kind;
        int n;
        int k;
        int amp;
        longint v;

        residues_sent = 0;
        chains_closed = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n                 <= 1'b0;
        item_ch.valid           <= 1'b0;
        item_ch.pos_x           <= '0;
        item_ch.pos_y           <= '0;
        item_ch.pos_z           <= '0;
        item_ch.chain_end       <= 1'b0;
        cfg_ch.valid            <= 1'b0;
        cfg_ch.tolerance_factor <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: clean helix, extreme coordinates, coincident points, short chains
        send_helix_chain(7, 0, 1'b1, -1);
        for (k = 0; k < hdwc_pkg::WINDOW_LEN; k++) begin
            v = (k % 2) ? 524287 : -524288;
            send_residue(v, v, v, k == hdwc_pkg::WINDOW_LEN - 1);
        end
        for (k = 0; k < hdwc_pkg::WINDOW_LEN; k++)
            send_residue(1234, -5678, 91011, k == hdwc_pkg::WINDOW_LEN - 1);
        send_noise(1'b1);
        for (k = 0; k < 3; k++)
            send_noise(k == 2);
        wait_for_labels();

        // Random phases, each under its own tolerance; the flow-control mix changes every two phases
        for (phase = 0; phase < 6; phase++) begin
            if (phase < 2) begin
                send_idle_pct = 34;
                recv_idle_pct = 86;
            end else if (phase < 4) begin
                send_idle_pct = 86;
                recv_idle_pct = 34;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_tolerance(tolerance_for_phase(phase));
            phase_start = residues_sent;
            while (residues_sent - phase_start < 42) begin
                kind = $urandom_range(0, 9);
                case ($urandom_range(0, 2))
                    0:       amp = 0;
                    1:       amp = 120;
                    default: amp = 400;
                endcase
                if (kind <= 5) begin
                    send_helix_chain($urandom_range(6, 16), amp,
                                     $urandom_range(0, 7) != 0, -1);
                end else if (kind == 6) begin
                    send_helix_chain($urandom_range(7, 14), 0, 1'b1,
                                     $urandom_range(0, 6));
                end else if (kind == 7) begin
                    n = $urandom_range(1, 5);
                    for (k = 0; k < n; k++)
                        send_noise(k == n - 1);
                end else begin
                    n = $urandom_range(1, 8);
                    for (k = 0; k < n; k++)
                        send_noise($urandom_range(0, 3) == 0);
                end
            end
            send_noise(1'b1);
            wait_for_labels();
        end

        $display("Covered %0d residues in %0d chains across six tolerance settings (0 to 1023),",
                 residues_sent, chains_closed);
        $display("checking %0d labels (%0d helix) under skewed, swapped and no idling.",
                 labels_seen, helix_seen);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
